// ----- rtl/tasp_pkg.sv -----
package tasp_pkg;

	localparam int STEP_W     = 16;
	localparam int CLK_W      = 28;
	localparam int POS_OUT_W  = 32;
	localparam int DIV_W      = 28;
	localparam int IV_W       = 28;
	localparam int BUDGET_W   = STEP_W + 2;

	localparam int X_RATE      = 1000;
	localparam int SINGLE_RATE = 2000;
	localparam int RATE_SCALE  = 1000;

	// ceil(2^RECIP_SHIFT / X_RATE): exact quotient for any CLK_W-bit clock value;
	// SINGLE_RATE is twice X_RATE, so its quotient is that one shifted right once
	localparam int                 RECIP_W      = 29;
	localparam int                 RECIP_SHIFT  = 38;
	localparam logic [RECIP_W-1:0] RECIP_X_RATE = 29'd274877907;

	localparam logic [CLK_W-1:0] CLK_HZ_RESET = 28'd72000000;

	localparam logic OP_RATE  = 1'b0;
	localparam logic OP_CLK_Y = 1'b1;

	typedef struct packed {
		logic                     mode;
		logic signed [STEP_W-1:0] x_steps;
		logic signed [STEP_W-1:0] y_steps;
	} in_t;

	typedef struct packed {
		logic                        x_step_level;
		logic                        y_step_level;
		logic                        x_direction;
		logic                        y_direction;
		logic                        busy_res;
		logic                        done_res;
		logic                        rejected;
		logic signed [POS_OUT_W-1:0] x_position;
		logic signed [POS_OUT_W-1:0] y_position;
	} out_t;

	typedef struct packed {
		logic       res_load;
		logic       rej;
		logic       tick;
		logic       move_load;
		logic       iv_load;
		logic       div_start;
		logic       div_op;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic active;
		logic both_nz;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/tasp_divider.sv -----
module tasp_divider #(
	parameter int W = 28
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     n_q;
	logic [W-1:0]     d_q;
	logic [W-1:0]     r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [W:0]       r_shift;
	logic [W:0]       r_sub;
	logic             fits;

	assign r_shift = {r_q, n_q[W-1]};
	assign r_sub   = r_shift - {1'b0, d_q};
	assign fits    = r_shift >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (run_q) begin
			if (fits) begin
				r_q <= r_sub[W-1:0];
				n_q <= {n_q[W-2:0], 1'b1};
			end else begin
				r_q <= r_shift[W-1:0];
				n_q <= {n_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = n_q;

endmodule

// ----- rtl/tasp_datapath.sv -----
module tasp_datapath #(
	parameter int POSITION_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tasp_pkg::CLK_W-1:0]   cfg_wdata,
	input  tasp_pkg::in_t                in_data,
	input  logic                         out_ready,
	output logic                         out_valid,
	output tasp_pkg::out_t               out_data,
	input  tasp_pkg::cmd_t               cmd,
	output tasp_pkg::sts_t               sts
);

	import tasp_pkg::*;

	localparam int PROD_W = CLK_W + RECIP_W;
	localparam int Q_W    = PROD_W - RECIP_SHIFT;

	logic [CLK_W-1:0]          clk_hz_q;
	logic                      x_pin_q, y_pin_q, x_dir_q, y_dir_q;
	logic [POSITION_WIDTH-1:0] x_accum_q, y_accum_q;
	logic [BUDGET_W-1:0]       budget_q;
	logic [IV_W-1:0]           x_iv_q, y_iv_q, x_cd_q, y_cd_q;
	logic [DIV_W-1:0]          rate_q;
	logic                      x_on_q, y_on_q, active_q;
	logic [STEP_W-1:0]         ax_q, ay_q;
	logic                      op_q;
	logic                      out_valid_q;
	out_t                      out_q;

	logic                      nx_x_pin, nx_y_pin, nx_x_dir, nx_y_dir;
	logic [POSITION_WIDTH-1:0] nx_x_accum, nx_y_accum;
	logic [BUDGET_W-1:0]       nx_budget;
	logic [IV_W-1:0]           nx_x_cd, nx_y_cd;
	logic                      nx_x_on, nx_y_on, nx_active;
	logic [STEP_W-1:0]         nx_ax, nx_ay;
	logic                      tick_done;

	logic                      x_neg, y_neg;
	logic [STEP_W-1:0]         xs_u, ys_u, ax_in, ay_in;
	logic [STEP_W:0]           mag_sum;
	logic                      xe, ye;
	logic [1:0]                dec;
	logic                      both_nz;

	logic [DIV_W-1:0]          div_n, div_d, div_q;
	logic                      div_done;
	logic [IV_W-1:0]           iv_clamped;
	logic [DIV_W-1:0]          rate_clamped;

	logic [PROD_W-1:0]         recip_prod;
	logic [Q_W-1:0]            q_x_rate;
	logic [Q_W-2:0]            q_single;
	logic [IV_W-1:0]           iv_x_both, iv_single;

	always_comb begin
		case (cmd.div_op)
			OP_RATE: begin
				div_n = DIV_W'(ay_q) * DIV_W'(RATE_SCALE);
				div_d = DIV_W'(ax_q);
			end
			OP_CLK_Y: begin
				div_n = DIV_W'(clk_hz_q);
				div_d = rate_q;
			end
			default: begin
				div_n = DIV_W'(ay_q) * DIV_W'(RATE_SCALE);
				div_d = DIV_W'(ax_q);
			end
		endcase
	end

	tasp_divider #(
		.W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	assign iv_clamped   = (div_q[IV_W-1:0] == '0) ? IV_W'(1) : div_q[IV_W-1:0];
	assign rate_clamped = (div_q == '0) ? DIV_W'(1) : div_q;

	// fixed-rate intervals by reciprocal multiplication
	assign recip_prod = {{RECIP_W{1'b0}}, clk_hz_q} * {{CLK_W{1'b0}}, RECIP_X_RATE};
	assign q_x_rate   = recip_prod[RECIP_SHIFT +: Q_W];
	assign q_single   = q_x_rate[Q_W-1:1];
	assign iv_x_both  = (q_x_rate == '0) ? IV_W'(1) : {{(IV_W-Q_W){1'b0}}, q_x_rate};
	assign iv_single  = (q_single == '0) ? IV_W'(1) : {{(IV_W-Q_W+1){1'b0}}, q_single};

	assign x_neg   = in_data.x_steps[STEP_W-1];
	assign y_neg   = in_data.y_steps[STEP_W-1];
	assign xs_u    = in_data.x_steps;
	assign ys_u    = in_data.y_steps;
	assign ax_in   = x_neg ? (~xs_u + 1'b1) : xs_u;
	assign ay_in   = y_neg ? (~ys_u + 1'b1) : ys_u;
	assign mag_sum = {1'b0, ax_in} + {1'b0, ay_in};

	assign xe  = x_on_q && (x_cd_q <= IV_W'(1));
	assign ye  = y_on_q && (y_cd_q <= IV_W'(1));
	assign dec = {1'b0, xe} + {1'b0, ye};

	assign both_nz = (ax_q != '0) && (ay_q != '0);

	always_comb begin
		nx_x_pin   = x_pin_q;
		nx_y_pin   = y_pin_q;
		nx_x_dir   = x_dir_q;
		nx_y_dir   = y_dir_q;
		nx_x_accum = x_accum_q;
		nx_y_accum = y_accum_q;
		nx_budget  = budget_q;
		nx_x_cd    = x_cd_q;
		nx_y_cd    = y_cd_q;
		nx_x_on    = x_on_q;
		nx_y_on    = y_on_q;
		nx_active  = active_q;
		nx_ax      = ax_q;
		nx_ay      = ay_q;
		tick_done  = 1'b0;

		if (cmd.move_load) begin
			nx_x_accum = x_accum_q + POSITION_WIDTH'(in_data.x_steps);
			nx_y_accum = y_accum_q + POSITION_WIDTH'(in_data.y_steps);
			nx_x_dir   = !x_neg && (ax_in != '0);
			nx_y_dir   = !y_neg && (ay_in != '0);
			nx_budget  = {mag_sum, 1'b0};
			nx_ax      = ax_in;
			nx_ay      = ay_in;
			nx_x_on    = 1'b0;
			nx_y_on    = 1'b0;
			nx_active  = 1'b1;
		end

		if (cmd.tick && active_q) begin
			if (x_on_q) begin
				nx_x_cd = xe ? x_iv_q : x_cd_q - 1'b1;
			end
			if (y_on_q) begin
				nx_y_cd = ye ? y_iv_q : y_cd_q - 1'b1;
			end
			if (xe || ye) begin
				if (budget_q != '0) begin
					nx_x_pin  = x_pin_q ^ xe;
					nx_y_pin  = y_pin_q ^ ye;
					nx_budget = (budget_q > BUDGET_W'(dec)) ? budget_q - BUDGET_W'(dec) : '0;
				end else begin
					nx_x_on   = 1'b0;
					nx_y_on   = 1'b0;
					nx_active = 1'b0;
					tick_done = 1'b1;
				end
			end
		end

		if (cmd.finish) begin
			nx_x_on = (ay_q == '0) || (ax_q != '0);
			nx_y_on = ay_q != '0;
			nx_x_cd = x_iv_q;
			nx_y_cd = y_iv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q    <= CLK_HZ_RESET;
			x_pin_q     <= 1'b0;
			y_pin_q     <= 1'b0;
			x_dir_q     <= 1'b0;
			y_dir_q     <= 1'b0;
			x_accum_q   <= '0;
			y_accum_q   <= '0;
			budget_q    <= '0;
			x_cd_q      <= '0;
			y_cd_q      <= '0;
			x_on_q      <= 1'b0;
			y_on_q      <= 1'b0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				clk_hz_q <= cfg_wdata;
			end
			x_pin_q   <= nx_x_pin;
			y_pin_q   <= nx_y_pin;
			x_dir_q   <= nx_x_dir;
			y_dir_q   <= nx_y_dir;
			x_accum_q <= nx_x_accum;
			y_accum_q <= nx_y_accum;
			budget_q  <= nx_budget;
			x_cd_q    <= nx_x_cd;
			y_cd_q    <= nx_y_cd;
			x_on_q    <= nx_x_on;
			y_on_q    <= nx_y_on;
			active_q  <= nx_active;
			if (cmd.res_load || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ax_q <= nx_ax;
		ay_q <= nx_ay;
		if (cmd.div_start) begin
			op_q <= cmd.div_op;
		end
		if (cmd.iv_load) begin
			if (both_nz) begin
				x_iv_q <= iv_x_both;
			end else if (ay_q == '0) begin
				x_iv_q <= iv_single;
			end else begin
				y_iv_q <= iv_single;
			end
		end
		if (div_done) begin
			case (op_q)
				OP_RATE: rate_q <= rate_clamped;
				OP_CLK_Y: y_iv_q <= iv_clamped;
				default: rate_q <= rate_clamped;
			endcase
		end
		if (cmd.res_load || cmd.finish) begin
			out_q.x_step_level <= nx_x_pin;
			out_q.y_step_level <= nx_y_pin;
			out_q.x_direction  <= nx_x_dir;
			out_q.y_direction  <= nx_y_dir;
			out_q.busy_res     <= nx_active;
			out_q.done_res     <= tick_done;
			out_q.rejected     <= cmd.rej;
			out_q.x_position   <= POS_OUT_W'(nx_x_accum);
			out_q.y_position   <= POS_OUT_W'(nx_y_accum);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.div_done = div_done;
	assign sts.active   = active_q;
	assign sts.both_nz  = both_nz;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

// ----- rtl/tasp_ctrl.sv -----
module tasp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_mode,
	output logic           in_ready,
	input  tasp_pkg::sts_t sts,
	output tasp_pkg::cmd_t cmd
);

	import tasp_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOAD   = 3'd1;
	localparam logic [2:0] ST_DIV2   = 3'd3;
	localparam logic [2:0] ST_YSTART = 3'd4;
	localparam logic [2:0] ST_DIV3   = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE) && sts.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d       = state_q;
		cmd.res_load  = 1'b0;
		cmd.rej       = 1'b0;
		cmd.tick      = 1'b0;
		cmd.move_load = 1'b0;
		cmd.iv_load   = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_op    = OP_RATE;
		cmd.finish    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_mode && !sts.active) begin
						cmd.move_load = 1'b1;
						state_d       = ST_LOAD;
					end else begin
						cmd.res_load = 1'b1;
						cmd.rej      = in_mode;
						cmd.tick     = !in_mode;
					end
				end
			end
			ST_LOAD: begin
				cmd.iv_load = 1'b1;
				if (sts.both_nz) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = OP_RATE;
					state_d       = ST_DIV2;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV2: begin
				if (sts.div_done) begin
					state_d = ST_YSTART;
				end
			end
			ST_YSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = OP_CLK_Y;
				state_d       = ST_DIV3;
			end
			ST_DIV3: begin
				if (sts.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/two_axis_step_pulse_generator.sv -----
// Channel  Signals                          Content
// in       in_valid, in_ready, in_data      tick or move command (mode, x_steps, y_steps)
// out      out_valid, out_ready, out_data   pin levels, directions, status, positions
// cfg      cfg_we, cfg_wdata                timer_clock_hz, written with no wait
//
// A tick or a rejected move completes on acceptance; the result is registered and a new
// transaction is taken once the result register is empty or is being read out.
// An accepted move with at most one axis moving passes the load and finish states before its
// result is registered; with both moving, two radix-2 divisions run between them. No input is
// taken meanwhile, and a stalled result holds off the input. arst_n clears the control, pin,
// position and valid state, not the intervals; timer_clock_hz resets to 72000000.
module two_axis_step_pulse_generator #(
	parameter int POSITION_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tasp_pkg::CLK_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  tasp_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output tasp_pkg::out_t              out_data
);

	import tasp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tasp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (in_data.mode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tasp_datapath #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
